[sv/hrp_pkg.sv]
package hrp_pkg;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   // Parse phase of the current line, one-hot.
   typedef enum logic [5:0] {
      PH_METHOD  = 6'b000001,
      PH_URI     = 6'b000010,
      PH_VERSION = 6'b000100,
      PH_KEY     = 6'b001000,
      PH_GAP     = 6'b010000,
      PH_VALUE   = 6'b100000
   } phase_type;

   typedef enum logic [2:0] {
      ROLE_DROP    = 3'd0,
      ROLE_METHOD  = 3'd1,
      ROLE_URI     = 3'd2,
      ROLE_VERSION = 3'd3,
      ROLE_KEY     = 3'd4,
      ROLE_VALUE   = 3'd5,
      ROLE_HALTED  = 3'd6
   } role_type;

   typedef enum logic [1:0] {
      METH_NONE = 2'd0,
      METH_GET  = 2'd1,
      METH_PUT  = 2'd2,
      METH_POST = 2'd3
   } method_type;

   typedef enum logic [1:0] {
      PEND_NONE = 2'd0,
      PEND_CR   = 2'd1,
      PEND_LF   = 2'd2
   } pend_type;

   typedef enum logic [1:0] {
      HALT_RUN   = 2'd0,
      HALT_DONE  = 2'd1,
      HALT_ERROR = 2'd2
   } halt_type;

   localparam logic [3:0] POS_MAX     = 4'd15;
   localparam logic [3:0] VERSION_LEN = 4'd8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_request;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic [2:0] byte_role;
      logic       line_end;
      logic       head_complete;
      logic       corrupted;
      logic [1:0] method_code;
      logic       minor_version;
      logic       proxy_request;
   } rsp_payload_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] pos;
      logic [2:0] method_cand;   // bit 0 GET, bit 1 PUT, bit 2 POST
      logic [1:0] version_cand;  // bit 0 HTTP/1.0, bit 1 HTTP/1.1
      logic       uri_seen;
      logic       proxy_mark;
      pend_type   pend;
      method_type method_held;
      logic       minor_held;
      halt_type   halt;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:        PH_METHOD,
      pos:          4'd0,
      method_cand:  3'b111,
      version_cand: 2'b11,
      uri_seen:     1'b0,
      proxy_mark:   1'b0,
      pend:         PEND_NONE,
      method_held:  METH_NONE,
      minor_held:   1'b0,
      halt:         HALT_RUN
   };

   // Methods whose text has character b at position pos.
   function automatic logic [2:0] method_match(input logic [7:0] b, input logic [3:0] pos);
      logic [2:0] m;
      m = 3'b000;
      unique case (pos)
         4'd0: m = {b == "P", b == "P", b == "G"};
         4'd1: m = {b == "O", b == "U", b == "E"};
         4'd2: m = {b == "S", b == "T", b == "T"};
         4'd3: m = {b == "T", 1'b0, 1'b0};
         default: m = 3'b000;
      endcase
      return m;
   endfunction

   // Versions whose text has character b at position pos.
   function automatic logic [1:0] version_match(input logic [7:0] b, input logic [3:0] pos);
      logic [1:0] m;
      m = 2'b00;
      unique case (pos)
         4'd0: m = {2{b == "H"}};
         4'd1: m = {2{b == "T"}};
         4'd2: m = {2{b == "T"}};
         4'd3: m = {2{b == "P"}};
         4'd4: m = {2{b == "/"}};
         4'd5: m = {2{b == "1"}};
         4'd6: m = {2{b == "."}};
         4'd7: m = {b == "1", b == "0"};
         default: m = 2'b00;
      endcase
      return m;
   endfunction

endpackage

[sv/hrp_step.sv]
module hrp_step (
   input  hrp_pkg::parse_state_type state_cur,
   input  hrp_pkg::req_payload_type item,
   output hrp_pkg::parse_state_type state_next,
   output hrp_pkg::rsp_payload_type result
);
   import hrp_pkg::*;

   parse_state_type s;
   parse_state_type n;
   logic [7:0]      b;
   logic            is_term;
   logic            swallowed;
   role_type        role;
   logic            lend;
   method_type      code;
   logic [3:0]      pos_bump;

   always_comb begin
      b         = item.data_byte;
      s         = item.new_request ? STATE_RESET : state_cur;
      n         = s;
      n.pend    = PEND_NONE;
      is_term   = (b == CHAR_CR) || (b == CHAR_LF);
      swallowed = ((s.pend == PEND_CR) && (b == CHAR_LF)) ||
                  ((s.pend == PEND_LF) && (b == CHAR_CR));
      role      = ROLE_DROP;
      lend      = 1'b0;
      pos_bump  = (s.pos == POS_MAX) ? s.pos : s.pos + 4'd1;

      priority if (s.method_cand[0]) code = METH_GET;
      else if (s.method_cand[1])     code = METH_PUT;
      else if (s.method_cand[2])     code = METH_POST;
      else                           code = METH_NONE;

      if (swallowed) begin
         role = ROLE_DROP;
      end else if (s.halt != HALT_RUN) begin
         role = ROLE_HALTED;
      end else if (is_term) begin
         lend   = 1'b1;
         n.pend = (b == CHAR_CR) ? PEND_CR : PEND_LF;
         if ((s.phase == PH_METHOD) || (s.phase == PH_URI) || (s.phase == PH_VERSION)) begin
            // End of the request line: it passes only from the version phase.
            n.halt = HALT_ERROR;
            if (s.phase == PH_VERSION) begin
               n.method_held = code;
               if ((code != METH_NONE) && (s.pos == VERSION_LEN) &&
                   (s.version_cand != 2'b00)) begin
                  n.minor_held = ~s.version_cand[0];
                  if (s.uri_seen) begin
                     n.halt  = HALT_RUN;
                     n.phase = PH_KEY;
                     n.pos   = 4'd0;
                  end
               end
            end
         end else if (s.phase == PH_KEY) begin
            // An empty header line ends the head; a key without a colon is corrupt.
            n.halt = (s.pos == 4'd0) ? HALT_DONE : HALT_ERROR;
         end else begin
            n.phase = PH_KEY;
            n.pos   = 4'd0;
         end
      end else begin
         unique case (s.phase)
            PH_METHOD: begin
               if (b == CHAR_SPACE) begin
                  n.method_cand = s.method_cand &
                                  {s.pos == 4'd4, s.pos == 4'd3, s.pos == 4'd3};
                  n.pos   = 4'd0;
                  n.phase = PH_URI;
               end else begin
                  role          = ROLE_METHOD;
                  n.method_cand = s.method_cand & method_match(b, s.pos);
                  n.pos         = pos_bump;
               end
            end
            PH_URI: begin
               if (b == CHAR_SPACE) begin
                  n.pos   = 4'd0;
                  n.phase = PH_VERSION;
               end else begin
                  role = ROLE_URI;
                  if (!s.uri_seen) begin
                     n.uri_seen   = 1'b1;
                     n.proxy_mark = (b != CHAR_SLASH);
                  end
               end
            end
            PH_VERSION: begin
               if (b == CHAR_SPACE) begin
                  n.version_cand = 2'b00;
               end else begin
                  role           = ROLE_VERSION;
                  n.version_cand = s.version_cand & version_match(b, s.pos);
                  n.pos          = pos_bump;
               end
            end
            PH_KEY: begin
               if (b == CHAR_COLON) begin
                  n.phase = PH_GAP;
               end else begin
                  role  = ROLE_KEY;
                  n.pos = pos_bump;
               end
            end
            PH_GAP: begin
               if (b != CHAR_SPACE) begin
                  role    = ROLE_VALUE;
                  n.phase = PH_VALUE;
               end
            end
            PH_VALUE: role = ROLE_VALUE;
            default:  role = ROLE_VALUE;
         endcase
      end

      state_next           = n;
      result.byte_value    = b;
      result.byte_role     = role;
      result.line_end      = lend;
      result.head_complete = (n.halt == HALT_DONE);
      result.corrupted     = (n.halt == HALT_ERROR);
      result.method_code   = n.method_held;
      result.minor_version = n.minor_held;
      result.proxy_request = n.proxy_mark &&
                             ((n.phase == PH_KEY) || (n.phase == PH_GAP) ||
                              (n.phase == PH_VALUE));
   end

endmodule

[sv/http_request_head_parser.sv]
// HTTP request head parser.
// The req_ channel carries one byte of the request head per transaction, with
// new_request set on the first byte of a new request to clear all parse state.
// The rsp_ channel returns one transaction for every byte: the byte echoed, its
// role (method, URI, version, header key, header value, delimiter or received
// while halted), a line-end flag and the running status: head complete,
// corrupted, method, minor version and proxy flag.
// A byte accepted on req_ is captured in an input register, then one pass of
// compare and state-update logic writes the result register and the parse
// state at the same edge; its result is then on rsp_, with rsp_valid high.
// Throughput is one byte per cycle while the receiver does not stall, set by
// the single state-update pass. Reset clears the valid flags of both registers
// and returns the parse state to the start of a request line. When the
// receiver stalls, the result register holds its transaction, the input
// register still takes one more byte, and req_ready then drops until rsp_ready
// frees the result register.
module http_request_head_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  hrp_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output hrp_pkg::rsp_payload_type rsp_payload
);
   import hrp_pkg::*;

   // Input register.
   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_data_ff;

   // Result register.
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_data_ff;

   // Parse state, updated whenever a byte moves from input to result register.
   parse_state_type state_ff;
   parse_state_type state_in;
   rsp_payload_type step_result;

   logic advance;
   logic take;

   hrp_step u_step (
      .state_cur  (state_ff),
      .item       (in_data_ff),
      .state_next (state_in),
      .result     (step_result)
   );

   // A byte advances when the result register is empty or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule
